[sv/sliding_window_maximum_unit_defines.svh]
// Assertion macros shared by the sliding window maximum unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_DEFINES_SVH

// Same-cycle implication check, disabled while reset is asserted.
`define SWM_ASSERT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("sliding window maximum check failed");

// Next-cycle implication check, disabled while reset is asserted.
`define SWM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("sliding window maximum check failed");

`endif

[sv/swm_pkg.sv]
// Shared constants and types of the sliding window maximum unit.
// Used by the controller, the datapath and the top level; no dependencies.
package swm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MAX_WIN    = 64;
	localparam int ADDR_W     = $clog2(MAX_WIN);
	localparam int LEN_W      = 7;
	localparam int CNT_W      = ADDR_W + 1;
	localparam int POS_W      = ADDR_W + 1;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic [POS_W-1:0]           pos;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic ret_step;
		logic pop_step;
		logic hv_load;
		logic push;
		logic rd_tail;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic count_one;
		logic retire_hit;
		logic pop_hit;
		logic out_blocked;
	} sts_t;

endpackage

[sv/swm_ctrl.sv]
// Sequencer of the sliding window maximum unit: walks the head retire loop,
// the tail pop loop and the push for each beat. Depends on swm_pkg.
module swm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_stall,
	input  swm_pkg::sts_t sts,
	output swm_pkg::cmd_t cmd
);
	import swm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RET_ADDR,
		ST_RET_CHK,
		ST_POP_ADDR,
		ST_POP_CHK,
		ST_PUSH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) state_q <= ST_RET_ADDR;
				end
				ST_RET_ADDR: begin
					state_q <= sts.count_zero ? ST_PUSH : ST_RET_CHK;
				end
				ST_RET_CHK: begin
					if (!sts.retire_hit) state_q <= ST_POP_ADDR;
					else if (sts.count_one) state_q <= ST_PUSH;
					else state_q <= ST_RET_ADDR;
				end
				ST_POP_ADDR: begin
					state_q <= ST_POP_CHK;
				end
				ST_POP_CHK: begin
					if (sts.pop_hit && !sts.count_one) state_q <= ST_POP_ADDR;
					else state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!sts.out_blocked) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == ST_IDLE) && sample_valid;
		cmd.ret_step = (state_q == ST_RET_CHK) && sts.retire_hit;
		cmd.hv_load  = (state_q == ST_RET_CHK) && !sts.retire_hit;
		cmd.rd_tail  = (state_q == ST_POP_ADDR);
		cmd.pop_step = (state_q == ST_POP_CHK) && sts.pop_hit;
		cmd.push     = (state_q == ST_PUSH) && !sts.out_blocked;
	end

endmodule

[sv/swm_datapath.sv]
// Datapath of the sliding window maximum unit: queue memory, pointers,
// counters, window length register and result register. Depends on swm_pkg.
`include "sliding_window_maximum_unit_defines.svh"
module swm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swm_pkg::LEN_W-1:0]     cfg_wdata,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  logic                          first_of_sequence,
	input  logic                          last_of_sequence,
	output logic signed [swm_pkg::SAMPLE_W-1:0] window_max,
	output logic                          last_result,
	output logic                          result_valid,
	input  logic                          result_stall,
	input  swm_pkg::cmd_t                 cmd,
	output swm_pkg::sts_t                 sts
);
	import swm_pkg::*;

	entry_t mem [MAX_WIN];
	entry_t rd_q;

	logic [LEN_W-1:0]           len_q;
	logic [ADDR_W-1:0]          head_q;
	logic [CNT_W-1:0]           count_q;
	logic [POS_W-1:0]           pos_q;
	logic [LEN_W-1:0]           seen_q;
	logic signed [SAMPLE_W-1:0] s_q;
	logic signed [SAMPLE_W-1:0] hv_q;
	logic                       last_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic                       rlast_q;
	logic                       rvalid_q;

	logic [ADDR_W-1:0] tail_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [POS_W-1:0]  age;
	logic [LEN_W-1:0]  seen_new;
	logic [LEN_W-1:0]  len_eff;
	logic              produce;

	// Zero counts as one and anything past the deepest window saturates.
	always_comb begin
		if (cfg_wdata == '0) len_eff = LEN_W'(1);
		else if (cfg_wdata > LEN_W'(MAX_WIN)) len_eff = LEN_W'(MAX_WIN);
		else len_eff = cfg_wdata;
	end

	assign tail_addr = head_q + count_q[ADDR_W-1:0] - ADDR_W'(1);
	assign wr_addr   = head_q + count_q[ADDR_W-1:0];
	assign rd_addr   = cmd.rd_tail ? tail_addr : head_q;
	// Positions wrap at twice the deepest window, so the age is a plain wrapped difference.
	assign age       = pos_q - rd_q.pos;
	assign seen_new  = (seen_q < len_q) ? seen_q + LEN_W'(1) : seen_q;
	assign produce   = (seen_new >= len_q);

	assign sts.count_zero  = (count_q == '0);
	assign sts.count_one   = (count_q == CNT_W'(1));
	assign sts.retire_hit  = (LEN_W'(age) >= len_q);
	assign sts.pop_hit     = (rd_q.value <= s_q);
	assign sts.out_blocked = rvalid_q && result_stall;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= '{value: s_q, pos: pos_q};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LEN_RESET;
			head_q   <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			seen_q   <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cfg_we) len_q <= len_eff;
			if (rvalid_q && !result_stall && !(cmd.push && produce)) rvalid_q <= 1'b0;
			if (cmd.accept) begin
				if (first_of_sequence) begin
					head_q  <= '0;
					count_q <= '0;
					pos_q   <= '0;
					seen_q  <= '0;
				end else if (seen_q > len_q) begin
					seen_q <= len_q;
				end
			end
			if (cmd.ret_step) begin
				head_q  <= head_q + ADDR_W'(1);
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.pop_step) count_q <= count_q - CNT_W'(1);
			if (cmd.push) begin
				if (produce) rvalid_q <= 1'b1;
				if (last_q) begin
					head_q  <= '0;
					count_q <= '0;
					pos_q   <= '0;
					seen_q  <= '0;
				end else begin
					count_q <= count_q + CNT_W'(1);
					pos_q   <= pos_q + POS_W'(1);
					seen_q  <= seen_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			s_q    <= sample;
			last_q <= last_of_sequence;
		end
		if (cmd.hv_load) hv_q <= rd_q.value;
		// An empty queue at push time means the new beat is its own window maximum.
		if (cmd.push && produce) begin
			max_q   <= (count_q == '0) ? s_q : hv_q;
			rlast_q <= last_q;
		end
	end

	assign window_max   = max_q;
	assign last_result  = rlast_q;
	assign result_valid = rvalid_q;

	`SWM_ASSERT(a_push_room, clk, arst_n, cmd.push, count_q < CNT_W'(MAX_WIN))
	`SWM_ASSERT(a_push_no_drop, clk, arst_n, cmd.push, !(rvalid_q && result_stall))
	`SWM_ASSERT(a_step_nonempty, clk, arst_n, cmd.ret_step || cmd.pop_step, count_q != '0)
	`SWM_ASSERT_NEXT(a_first_clears, clk, arst_n, cmd.accept && first_of_sequence, count_q == '0 && seen_q == '0)

endmodule

[sv/sliding_window_maximum_unit.sv]
// Top level of the sliding window maximum unit: joins the sequencer and the datapath.
// Depends on swm_pkg, swm_ctrl and swm_datapath.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------------
//  sample   | sample_valid / sample_stall  | sample, first_of_sequence, last_of_sequence
//  result   | result_valid / result_stall  | window_max, last_result
//  config   | cfg_we (no wait)             | cfg_wdata (window length)
//
// A beat is accepted in ST_IDLE, then each head probe and each tail probe takes an address
// state and a check state, since every probe goes through the single registered read port
// of the queue memory; the push comes last, and an empty queue goes straight to it.
// Reset (arst_n low) empties the queue and sets the window length to 3; the memory is kept.
// A new beat is accepted while a finished result waits; the push of the next
// beat holds only while the result register is still full and stalled.
module sliding_window_maximum_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swm_pkg::LEN_W-1:0]         cfg_wdata,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  logic                              first_of_sequence,
	input  logic                              last_of_sequence,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [swm_pkg::SAMPLE_W-1:0] window_max,
	output logic                              last_result
);
	import swm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	swm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	swm_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.sample            (sample),
		.first_of_sequence (first_of_sequence),
		.last_of_sequence  (last_of_sequence),
		.window_max        (window_max),
		.last_result       (last_result),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule

[bench/sliding_window_maximum_unit_tb.sv]
// Self-checking bench for sliding_window_maximum_unit: framed sample streams in, window maxima out.
// Holds its own monotonic-queue predictor and a scoreboard; depends on swm_pkg and the unit.
`timescale 1ns / 100ps

module sliding_window_maximum_unit_tb;
	import swm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int ITEM_GOAL = 650;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       first;
		logic                       last;
	} sample_beat_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} window_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [LEN_W-1:0]           cfg_wdata = '0;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       first_of_sequence = 1'b0;
	logic                       last_of_sequence = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] window_max;
	logic                       last_result;

	sample_beat_t   sample_backlog[$];
	window_result_t window_max_due[$];
	int             beats_queued = 0;
	int             beats_taken = 0;
	int             faults = 0;
	int             cycles = 0;
	bit             no_gaps = 1'b0;

	// Predictor state: candidate maxima, oldest at the head, falling toward the tail.
	logic signed [SAMPLE_W-1:0] cand_value[MAX_WIN];
	logic [POS_W-1:0]           cand_pos[MAX_WIN];
	logic [ADDR_W-1:0]          cand_head = '0;
	int                         cand_count = 0;
	logic [POS_W-1:0]           next_pos = '0;
	int                         seen_in_seq = 0;
	int                         win_len = int'(LEN_RESET);

	sliding_window_maximum_unit uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.sample            (sample),
		.first_of_sequence (first_of_sequence),
		.last_of_sequence  (last_of_sequence),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.window_max        (window_max),
		.last_result       (last_result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void restart_sequence();
		cand_head = '0;
		cand_count = 0;
		next_pos = '0;
		seen_in_seq = 0;
	endfunction

	// Advances the window by one sample and records the maximum it yields, if any.
	function automatic void track_window(input logic signed [SAMPLE_W-1:0] s,
			input logic first, input logic last);
		int                len;
		logic [POS_W-1:0]  pos;
		logic [ADDR_W-1:0] slot;
		window_result_t    res;
		len = (win_len == 0) ? 1 : ((win_len > MAX_WIN) ? MAX_WIN : win_len);
		if (first)
			restart_sequence();
		if (seen_in_seq > len)
			seen_in_seq = len;
		pos = next_pos;
		// Ages wrap with the position counter, which runs modulo twice the depth.
		while (cand_count > 0 && int'(POS_W'(pos - cand_pos[cand_head])) >= len) begin
			cand_head = cand_head + 1'b1;
			cand_count--;
		end
		while (cand_count > 0 && cand_value[ADDR_W'(cand_head + cand_count - 1)] <= s)
			cand_count--;
		if (cand_count >= MAX_WIN) begin
			cand_head = cand_head + 1'b1;
			cand_count--;
		end
		slot = ADDR_W'(cand_head + cand_count);
		cand_value[slot] = s;
		cand_pos[slot] = pos;
		cand_count++;
		next_pos = pos + 1'b1;
		if (seen_in_seq < len)
			seen_in_seq++;
		if (seen_in_seq >= len) begin
			res.value = cand_value[cand_head];
			res.last = last;
			window_max_due.insert(window_max_due.size(), res);
		end
		if (last)
			restart_sequence();
	endfunction

	// Sample side: predict on every accepted beat, then offer the next one.
	always @(posedge clk) begin
		sample_beat_t b;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				track_window(sample, first_of_sequence, last_of_sequence);
				beats_taken++;
			end
			if (!sample_valid || !sample_stall) begin
				if (sample_backlog.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 13)) begin
					b = sample_backlog[0];
					sample_backlog.delete(0);
					sample_valid <= 1'b1;
					sample <= b.value;
					first_of_sequence <= b.first;
					last_of_sequence <= b.last;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: random stall, and every accepted beat is checked in order.
	always @(posedge clk) begin
		window_result_t w;
		if (arst_n) begin
			result_stall <= !no_gaps && ($urandom_range(0, 99) < 13);
			if (result_valid && !result_stall) begin
				if (window_max_due.size() == 0) begin
					$error("unexpected result beat: window_max %0d last_result %0b",
						window_max, last_result);
					faults++;
				end else begin
					w = window_max_due[0];
					window_max_due.delete(0);
					if (window_max !== w.value) begin
						$error("window_max: expected %0d, actual %0d", w.value, window_max);
						faults++;
					end
					if (last_result !== w.last) begin
						$error("last_result: expected %0b, actual %0b", w.last, last_result);
						faults++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sliding_window_maximum_unit: mismatch");
			$finish;
		end
	end

	task automatic push_beat(input logic signed [SAMPLE_W-1:0] v, input logic first,
			input logic last);
		sample_beat_t b;
		b.value = v;
		b.first = first;
		b.last = last;
		sample_backlog.insert(sample_backlog.size(), b);
		beats_queued++;
	endtask

	// Waits until every beat is taken and answered, then lets a sample with no
	// result finish its queue walk.
	task automatic settle();
		do
			@(posedge clk);
		while (beats_taken != beats_queued || window_max_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input int len);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= LEN_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		win_len = len;
	endtask

	// One run of samples with a value pattern chosen by shape.
	task automatic push_run(input int n, input int shape, input bit open_flag,
			input bit close_flag);
		logic signed [SAMPLE_W-1:0] v;
		int k;
		v = SAMPLE_W'($urandom);
		for (k = 0; k < n; k++) begin
			case (shape)
				0: v = SAMPLE_W'($urandom);
				1: begin
					v = SAMPLE_W'($urandom_range(0, 6));
					v = v - 16'sd3;
				end
				2: v = v + SAMPLE_W'($urandom_range(0, 60));
				3: v = v - SAMPLE_W'($urandom_range(0, 60));
				default: begin
					case ($urandom_range(0, 3))
						0: v = 16'sh8000;
						1: v = 16'sh7fff;
						2: v = -16'sd1;
						default: v = '0;
					endcase
				end
			endcase
			push_beat(v, open_flag && (k == 0), close_flag && (k == n - 1));
		end
	endtask

	initial begin
		int lens[8] = '{64, 1, 2, 63, 5, 32, 17, 3};
		int ph;
		int len;
		int n;
		int r;
		int phase_items;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset window length of three.
		push_beat(16'sd100, 1'b0, 1'b0);        // no start flag right after reset
		push_beat(16'sh8000, 1'b0, 1'b0);
		push_beat(16'sh7fff, 1'b0, 1'b0);
		push_beat(16'sd5, 1'b0, 1'b0);
		push_beat(16'sd5, 1'b0, 1'b0);          // equal values
		push_beat(16'sd5, 1'b0, 1'b1);
		push_beat(16'sd7, 1'b1, 1'b0);          // sequence shorter than the window
		push_beat(-16'sd7, 1'b0, 1'b1);
		push_beat(16'sh8000, 1'b0, 1'b0);       // starts without a flag after an end
		push_beat(16'sh8000, 1'b0, 1'b0);
		push_beat(16'sh8000, 1'b0, 1'b1);
		push_beat(16'sd1, 1'b1, 1'b0);
		push_beat(16'sd2, 1'b0, 1'b0);
		push_beat(16'sd3, 1'b0, 1'b0);
		push_beat(16'sd9, 1'b1, 1'b0);          // restart in the middle of a sequence
		push_beat(16'sd8, 1'b0, 1'b0);
		push_beat(16'sd7, 1'b0, 1'b0);
		push_beat(16'sd6, 1'b0, 1'b0);
		push_beat(16'sd4, 1'b0, 1'b0);          // left open across the length change
		settle();
		set_window(1);
		push_beat(16'sd0, 1'b0, 1'b0);
		push_beat(16'sh7fff, 1'b0, 1'b0);
		push_beat(16'sh8000, 1'b0, 1'b1);
		settle();

		for (ph = 0; beats_queued < ITEM_GOAL; ph++) begin
			if (ph < 8)
				len = lens[ph];
			else if ($urandom_range(0, 1) == 0)
				len = $urandom_range(1, 8);
			else
				len = $urandom_range(1, 64);
			set_window(len);
			no_gaps = (ph == 3);
			phase_items = 0;
			while (phase_items < 70) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					push_beat(SAMPLE_W'($urandom), $urandom_range(0, 9) == 0,
						$urandom_range(0, 9) == 0);
					phase_items++;
				end else begin
					if (ph == 0 && phase_items == 0)
						n = 150;        // long enough for the position counter to wrap
					else if (r < 25)
						n = $urandom_range(1, len);
					else if (r >= 97)
						n = $urandom_range(130, 180);
					else
						n = len + $urandom_range(0, 20);
					push_run(n, $urandom_range(0, 4), $urandom_range(0, 7) != 0,
						$urandom_range(0, 9) != 0);
					phase_items += n;
				end
			end
			// End each phase inside a sequence so the next length lands mid-stream.
			push_run($urandom_range(1, 10), $urandom_range(0, 4), 1'b1, 1'b0);
			settle();
			no_gaps = 1'b0;
		end

		if (faults == 0 && window_max_due.size() == 0)
			$display("sliding_window_maximum_unit: match");
		else
			$display("sliding_window_maximum_unit: mismatch");
		$finish;
	end

endmodule
